// ----- sv/lba_pkg.sv -----
// ----------------------------------------------------------------------------
// Lease block allocator package
// Shared sizes, reset values and result codes of the allocator.
// ----------------------------------------------------------------------------
package lba_pkg;

	localparam int NUM_BLOCKS = 32768;
	localparam int ID_W       = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = ID_W + 1;
	localparam int BLK_W      = 16;
	localparam int TIME_W     = 24;
	localparam int KEY_W      = TIME_W + 1;
	localparam int LEASE_W    = 16;

	localparam logic [LEASE_W-1:0] LEASE_RESET = 16'd600;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_HIT       = 2'd1,
		ST_MISS      = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

endpackage

// ----- sv/lba_if.sv -----
// ----------------------------------------------------------------------------
// Lease block allocator channels
// Request, result and lease length write channels with valid and ready.
// ----------------------------------------------------------------------------
interface lba_req_if;
	import lba_pkg::*;
	logic                valid;
	logic                ready;
	logic                op;
	logic [TIME_W-1:0]   req_time;
	logic [BLK_W-1:0]    block_id;
	modport source (output valid, op, req_time, block_id, input ready);
	modport sink (input valid, op, req_time, block_id, output ready);
endinterface

interface lba_rsp_if;
	import lba_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [BLK_W-1:0]    granted_block;
	modport source (output valid, status, granted_block, input ready);
	modport sink (input valid, status, granted_block, output ready);
endinterface

interface lba_cfg_if;
	import lba_pkg::*;
	logic                valid;
	logic                ready;
	logic [LEASE_W-1:0]  lease_length;
	modport source (output valid, lease_length, input ready);
	modport sink (input valid, lease_length, output ready);
endinterface

// ----- sv/lba_ram.sv -----
// ----------------------------------------------------------------------------
// Lease block allocator RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/lease_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Lease block allocator
// Hands out the lowest free block and frees blocks whose lease has run out.
// ----------------------------------------------------------------------------
// Each request first frees expired blocks, each adding a pop of the held heap and a
// push onto the free heap; sifts move the held heap up and down and the free heap
// up and down level by level.
// Throughput: one request at a time; the next is taken the cycle after the result
// is registered, and a result still waiting holds the following one.
// Reset clears counters and control only; unused blocks come from a fresh-block counter.
module lease_block_allocator_unit (
	input  logic clk,
	input  logic arst_n,
	lba_req_if.sink   req,
	lba_rsp_if.source rsp,
	lba_cfg_if.sink   cfg
);
	import lba_pkg::*;

	localparam int NS = 32;

	typedef enum logic [NS-1:0] {
		S_IDLE       = 32'd1 << 0,
		S_EXP_CHK    = 32'd1 << 1,
		S_EXP_TOP    = 32'd1 << 2,
		S_EXP_CMP    = 32'd1 << 3,
		S_HPOP_LAST  = 32'd1 << 4,
		S_HPOP_KEY   = 32'd1 << 5,
		S_DN_CHK     = 32'd1 << 6,
		S_DN_L       = 32'd1 << 7,
		S_DN_LK      = 32'd1 << 8,
		S_DN_R       = 32'd1 << 9,
		S_DN_CMP     = 32'd1 << 10,
		S_DN_PLACE   = 32'd1 << 11,
		S_FPUSH_INIT = 32'd1 << 12,
		S_FU_CHK     = 32'd1 << 13,
		S_FU_CMP     = 32'd1 << 14,
		S_FU_PLACE   = 32'd1 << 15,
		S_DISPATCH   = 32'd1 << 16,
		S_FPOP_TOP   = 32'd1 << 17,
		S_FPOP_LAST  = 32'd1 << 18,
		S_FD_CHK     = 32'd1 << 19,
		S_FD_L       = 32'd1 << 20,
		S_FD_R       = 32'd1 << 21,
		S_FD_CMP     = 32'd1 << 22,
		S_FD_PLACE   = 32'd1 << 23,
		S_ALLOC      = 32'd1 << 24,
		S_UP_CHK     = 32'd1 << 25,
		S_UP_P       = 32'd1 << 26,
		S_UP_CMP     = 32'd1 << 27,
		S_UP_PLACE   = 32'd1 << 28,
		S_ACC_POS    = 32'd1 << 29,
		S_ACC_CHK    = 32'd1 << 30,
		S_FINISH     = 32'd1 << 31
	} state_t;

	typedef enum logic [1:0] {
		R_PUSH   = 2'd0,
		R_ACCESS = 2'd1,
		R_DONE   = 2'd2
	} ret_t;

	state_t              state_q;
	ret_t                ret_q;
	logic [LEASE_W-1:0]  lease_q;
	logic                op_q;
	logic [TIME_W-1:0]   now_q;
	logic [BLK_W-1:0]    blk_q;
	logic [KEY_W-1:0]    exp_q;
	logic [CNT_W-1:0]    hcnt_q;
	logic [CNT_W-1:0]    fcnt_q;
	logic [CNT_W-1:0]    nf_q;
	logic [ID_W-1:0]     pos_q;
	logic [ID_W-1:0]     id_q;
	logic [KEY_W-1:0]    key_q;
	logic [CNT_W-1:0]    c_q;
	logic [ID_W-1:0]     cid_q;
	logic [KEY_W-1:0]    ckey_q;
	logic [ID_W-1:0]     rid_q;
	logic [ID_W-1:0]     victim_q;
	status_t             status_q;
	logic [BLK_W-1:0]    granted_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [BLK_W-1:0]    out_block_q;

	logic                fh_we, hh_we, ex_we, ps_we;
	logic [ID_W-1:0]     fh_wa, hh_wa, ex_wa, ps_wa;
	logic [ID_W-1:0]     fh_wd, hh_wd, ps_wd;
	logic [KEY_W-1:0]    ex_wd;
	logic [ID_W-1:0]     fh_ra, hh_ra, ex_ra, ps_ra;
	logic [ID_W-1:0]     fh_rd, hh_rd, ps_rd;
	logic [KEY_W-1:0]    ex_rd;

	logic [CNT_W-1:0]    dn_c;
	logic [CNT_W:0]      c1;
	logic [ID_W-1:0]     parent;
	logic [CNT_W-1:0]    hcnt_m1;
	logic [CNT_W-1:0]    fcnt_m1;
	logic [ID_W-1:0]     blk_m1;
	logic [LEASE_W-1:0]  lease_eff;
	logic                blk_ok;
	logic                out_free;

	assign dn_c      = {pos_q, 1'b1};
	assign c1        = {1'b0, c_q} + (CNT_W+1)'(1);
	assign parent    = ID_W'((pos_q - ID_W'(1)) >> 1);
	assign hcnt_m1   = hcnt_q - CNT_W'(1);
	assign fcnt_m1   = fcnt_q - CNT_W'(1);
	assign blk_m1    = ID_W'(blk_q - BLK_W'(1));
	assign lease_eff = (lease_q == '0) ? LEASE_W'(1) : lease_q;
	assign blk_ok    = (blk_q != '0) && ({1'b0, blk_q} <= (BLK_W+1)'(NUM_BLOCKS));
	assign out_free  = !out_valid_q || rsp.ready;

	assign req.ready         = (state_q == S_IDLE);
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.granted_block = out_block_q;

	lba_ram #(.WIDTH(ID_W), .DEPTH(NUM_BLOCKS)) u_free_heap (
		.clk(clk), .we(fh_we), .waddr(fh_wa), .wdata(fh_wd), .raddr(fh_ra), .rdata(fh_rd)
	);
	lba_ram #(.WIDTH(ID_W), .DEPTH(NUM_BLOCKS)) u_held_heap (
		.clk(clk), .we(hh_we), .waddr(hh_wa), .wdata(hh_wd), .raddr(hh_ra), .rdata(hh_rd)
	);
	lba_ram #(.WIDTH(KEY_W), .DEPTH(NUM_BLOCKS)) u_expiry (
		.clk(clk), .we(ex_we), .waddr(ex_wa), .wdata(ex_wd), .raddr(ex_ra), .rdata(ex_rd)
	);
	lba_ram #(.WIDTH(ID_W), .DEPTH(NUM_BLOCKS)) u_position (
		.clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd)
	);

	always_comb begin
		fh_we = 1'b0; fh_wa = pos_q; fh_wd = id_q; fh_ra = '0;
		hh_we = 1'b0; hh_wa = pos_q; hh_wd = id_q; hh_ra = '0;
		ex_we = 1'b0; ex_wa = victim_q; ex_wd = exp_q; ex_ra = '0;
		ps_we = 1'b0; ps_wa = id_q; ps_wd = pos_q; ps_ra = blk_m1;
		unique case (state_q)
			S_EXP_TOP: begin
				ex_ra = hh_rd;
			end
			S_EXP_CMP: begin
				hh_ra = hcnt_m1[ID_W-1:0];
			end
			S_HPOP_LAST: begin
				ex_ra = hh_rd;
			end
			S_DN_CHK: begin
				hh_ra = dn_c[ID_W-1:0];
			end
			S_DN_L: begin
				ex_ra = hh_rd;
				hh_ra = c1[ID_W-1:0];
			end
			S_DN_LK: begin
				ex_ra = hh_rd;
			end
			S_DN_CMP: begin
				if (key_q > ckey_q) begin
					hh_we = 1'b1; hh_wd = cid_q;
					ps_we = 1'b1; ps_wa = cid_q;
				end
			end
			S_DN_PLACE, S_UP_PLACE: begin
				hh_we = 1'b1;
				ps_we = 1'b1;
			end
			S_FU_CHK: begin
				fh_ra = parent;
			end
			S_FU_CMP: begin
				if (victim_q < fh_rd) begin
					fh_we = 1'b1; fh_wd = fh_rd;
				end
			end
			S_FU_PLACE: begin
				fh_we = 1'b1; fh_wd = victim_q;
			end
			S_FPOP_TOP: begin
				fh_ra = fcnt_m1[ID_W-1:0];
			end
			S_FD_CHK: begin
				fh_ra = dn_c[ID_W-1:0];
			end
			S_FD_L: begin
				fh_ra = c1[ID_W-1:0];
			end
			S_FD_CMP: begin
				if (id_q > cid_q) begin
					fh_we = 1'b1; fh_wd = cid_q;
				end
			end
			S_FD_PLACE: begin
				fh_we = 1'b1;
			end
			S_ALLOC: begin
				ex_we = 1'b1;
			end
			S_UP_CHK: begin
				hh_ra = parent;
			end
			S_UP_P: begin
				ex_ra = hh_rd;
			end
			S_UP_CMP: begin
				if (key_q < ex_rd) begin
					hh_we = 1'b1; hh_wd = cid_q;
					ps_we = 1'b1; ps_wa = cid_q;
				end
			end
			S_ACC_POS: begin
				hh_ra = ps_rd;
			end
			S_ACC_CHK: begin
				if ((pos_q == ps_rd) && (hh_rd == blk_m1)) begin
					ex_we = 1'b1; ex_wa = blk_m1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= R_DONE;
			lease_q     <= LEASE_RESET;
			hcnt_q      <= '0;
			fcnt_q      <= '0;
			nf_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				lease_q <= cfg.lease_length;
			end
			if (out_valid_q && rsp.ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q      <= req.op;
						now_q     <= req.req_time;
						blk_q     <= req.block_id;
						exp_q     <= {1'b0, req.req_time} + {{(KEY_W-LEASE_W){1'b0}}, lease_eff}
							- KEY_W'(1);
						granted_q <= '0;
						state_q   <= S_EXP_CHK;
					end
				end
				S_EXP_CHK: begin
					state_q <= (hcnt_q == '0) ? S_DISPATCH : S_EXP_TOP;
				end
				S_EXP_TOP: begin
					victim_q <= hh_rd;
					state_q  <= S_EXP_CMP;
				end
				S_EXP_CMP: begin
					if (ex_rd < {1'b0, now_q}) begin
						hcnt_q  <= hcnt_m1;
						ret_q   <= R_PUSH;
						state_q <= (hcnt_m1 != '0) ? S_HPOP_LAST : S_FPUSH_INIT;
					end else begin
						state_q <= S_DISPATCH;
					end
				end
				S_HPOP_LAST: begin
					id_q    <= hh_rd;
					state_q <= S_HPOP_KEY;
				end
				S_HPOP_KEY: begin
					key_q   <= ex_rd;
					pos_q   <= '0;
					state_q <= S_DN_CHK;
				end
				S_DN_CHK: begin
					c_q     <= dn_c;
					state_q <= (dn_c < hcnt_q) ? S_DN_L : S_DN_PLACE;
				end
				S_DN_L: begin
					cid_q   <= hh_rd;
					state_q <= S_DN_LK;
				end
				S_DN_LK: begin
					ckey_q  <= ex_rd;
					rid_q   <= hh_rd;
					state_q <= (c1 < {1'b0, hcnt_q}) ? S_DN_R : S_DN_CMP;
				end
				S_DN_R: begin
					if (ex_rd < ckey_q) begin
						cid_q  <= rid_q;
						ckey_q <= ex_rd;
						c_q    <= c1[CNT_W-1:0];
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (key_q > ckey_q) begin
						pos_q   <= c_q[ID_W-1:0];
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_DN_PLACE;
					end
				end
				S_DN_PLACE: begin
					state_q <= (ret_q == R_PUSH) ? S_FPUSH_INIT : S_FINISH;
				end
				S_FPUSH_INIT: begin
					pos_q   <= fcnt_q[ID_W-1:0];
					state_q <= S_FU_CHK;
				end
				S_FU_CHK: begin
					state_q <= (pos_q != '0) ? S_FU_CMP : S_FU_PLACE;
				end
				S_FU_CMP: begin
					if (victim_q < fh_rd) begin
						pos_q   <= parent;
						state_q <= S_FU_CHK;
					end else begin
						state_q <= S_FU_PLACE;
					end
				end
				S_FU_PLACE: begin
					fcnt_q  <= fcnt_q + CNT_W'(1);
					state_q <= S_EXP_CHK;
				end
				S_DISPATCH: begin
					if (!op_q) begin
						if (fcnt_q != '0) begin
							state_q <= S_FPOP_TOP;
						end else if (nf_q == CNT_W'(NUM_BLOCKS)) begin
							status_q <= ST_EXHAUSTED;
							state_q  <= S_FINISH;
						end else begin
							victim_q <= nf_q[ID_W-1:0];
							nf_q     <= nf_q + CNT_W'(1);
							state_q  <= S_ALLOC;
						end
					end else if (blk_ok) begin
						state_q <= S_ACC_POS;
					end else begin
						status_q <= ST_MISS;
						state_q  <= S_FINISH;
					end
				end
				S_FPOP_TOP: begin
					victim_q <= fh_rd;
					fcnt_q   <= fcnt_m1;
					state_q  <= (fcnt_m1 != '0) ? S_FPOP_LAST : S_ALLOC;
				end
				S_FPOP_LAST: begin
					id_q    <= fh_rd;
					pos_q   <= '0;
					state_q <= S_FD_CHK;
				end
				S_FD_CHK: begin
					c_q     <= dn_c;
					state_q <= (dn_c < fcnt_q) ? S_FD_L : S_FD_PLACE;
				end
				S_FD_L: begin
					cid_q   <= fh_rd;
					state_q <= (c1 < {1'b0, fcnt_q}) ? S_FD_R : S_FD_CMP;
				end
				S_FD_R: begin
					if (fh_rd < cid_q) begin
						cid_q <= fh_rd;
						c_q   <= c1[CNT_W-1:0];
					end
					state_q <= S_FD_CMP;
				end
				S_FD_CMP: begin
					if (id_q > cid_q) begin
						pos_q   <= c_q[ID_W-1:0];
						state_q <= S_FD_CHK;
					end else begin
						state_q <= S_FD_PLACE;
					end
				end
				S_FD_PLACE: begin
					state_q <= S_ALLOC;
				end
				S_ALLOC: begin
					id_q      <= victim_q;
					key_q     <= exp_q;
					pos_q     <= hcnt_q[ID_W-1:0];
					hcnt_q    <= hcnt_q + CNT_W'(1);
					ret_q     <= R_DONE;
					status_q  <= ST_ALLOCATED;
					granted_q <= {1'b0, victim_q} + BLK_W'(1);
					state_q   <= S_UP_CHK;
				end
				S_UP_CHK: begin
					state_q <= (pos_q != '0) ? S_UP_P : S_UP_PLACE;
				end
				S_UP_P: begin
					cid_q   <= hh_rd;
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (key_q < ex_rd) begin
						pos_q   <= parent;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_UP_PLACE;
					end
				end
				S_UP_PLACE: begin
					if (ret_q == R_ACCESS) begin
						ret_q   <= R_DONE;
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_ACC_POS: begin
					pos_q <= ps_rd;
					if ({1'b0, ps_rd} < hcnt_q) begin
						state_q <= S_ACC_CHK;
					end else begin
						status_q <= ST_MISS;
						state_q  <= S_FINISH;
					end
				end
				S_ACC_CHK: begin
					if ((pos_q == ps_rd) && (hh_rd == blk_m1)) begin
						id_q     <= blk_m1;
						key_q    <= exp_q;
						ret_q    <= R_ACCESS;
						status_q <= ST_HIT;
						state_q  <= S_UP_CHK;
					end else begin
						status_q <= ST_MISS;
						state_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_block_q  <= granted_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- bench/lba_if.sv -----
// ----------------------------------------------------------------------------
// Lease block allocator bench channels
// The bench drives the request, result and lease length channels that are
// declared with the design, so that both sides share one definition.
// ----------------------------------------------------------------------------

// ----- bench/tb_lease_block_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Lease block allocator testbench
// Drives allocate and access requests with random gaps and stalls, predicts
// each result with a behavioral pool model and compares field by field.
// ----------------------------------------------------------------------------
module tb_lease_block_allocator_unit;
	import lba_pkg::*;

	typedef struct packed {
		logic              op;
		logic [TIME_W-1:0] req_time;
		logic [BLK_W-1:0]  block_id;
	} request_t;

	typedef struct packed {
		status_t          status;
		logic [BLK_W-1:0] granted_block;
	} grant_t;

	localparam int LIMIT = 4000000;
	localparam logic OP_ALLOC  = 1'b0;
	localparam logic OP_ACCESS = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lba_req_if req ();
	lba_rsp_if rsp ();
	lba_cfg_if cfg ();

	lease_block_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	request_t pending_q[$];
	grant_t   grant_q[$];
	int       errors = 0;
	int       cycles = 0;
	int       gap = 0;
	int       stall = 0;
	int       hold_off = 0;
	bit       hold_go = 0;
	bit       hold_done = 0;

	// Pool model: the lowest free block is found by scan; blocks are rarely
	// many held at once, so a flat array is cheap enough.
	bit             pool_held[1:NUM_BLOCKS];
	int unsigned    pool_expiry[1:NUM_BLOCKS];
	int unsigned    held_ids[$];
	logic [LEASE_W-1:0] lease_cur = LEASE_RESET;
	int unsigned    last_time = 0;

	function automatic grant_t predict_grant(request_t r);
		grant_t g;
		int unsigned lease;
		int unsigned expiry;
		int unsigned keep[$];
		lease = (lease_cur == 0) ? 1 : lease_cur;
		expiry = r.req_time + lease - 1;
		foreach (held_ids[i]) begin
			if (pool_expiry[held_ids[i]] < r.req_time) pool_held[held_ids[i]] = 0;
			else keep.push_back(held_ids[i]);
		end
		held_ids = keep;
		g.granted_block = '0;
		if (r.op == OP_ALLOC) begin
			g.status = ST_EXHAUSTED;
			for (int b = 1; b <= NUM_BLOCKS; b++) begin
				if (!pool_held[b]) begin
					pool_held[b] = 1;
					pool_expiry[b] = expiry;
					held_ids.push_back(b);
					g.status = ST_ALLOCATED;
					g.granted_block = b[BLK_W-1:0];
					break;
				end
			end
		end else if (r.block_id >= 1 && r.block_id <= NUM_BLOCKS && pool_held[r.block_id]) begin
			pool_expiry[r.block_id] = expiry;
			g.status = ST_HIT;
		end else begin
			g.status = ST_MISS;
		end
		return g;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Driver for the request channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= 1'b0;
			req.req_time <= '0;
			req.block_id <= '0;
			gap <= 0;
		end else if (req.valid && !req.ready) begin
		end else if (gap > 0) begin
			req.valid <= 1'b0;
			gap <= gap - 1;
		end else if (pending_q.size() > 0) begin
			request_t r;
			r = pending_q.pop_front();
			grant_q.push_back(predict_grant(r));
			req.valid <= 1'b1;
			req.op <= r.op;
			req.req_time <= r.req_time;
			req.block_id <= r.block_id;
			gap <= ($urandom_range(0, 3) == 0) ?
				(($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3)) : 0;
		end else begin
			req.valid <= 1'b0;
		end
	end

	// Monitor and result-side stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (grant_q.size() == 0) begin
					report_mismatch("unexpected result", rsp.status, -1);
				end else begin
					grant_t g;
					g = grant_q.pop_front();
					if (rsp.status !== g.status)
						report_mismatch("status", rsp.status, g.status);
					if (rsp.granted_block !== g.granted_block)
						report_mismatch("granted_block", rsp.granted_block, g.granted_block);
				end
			end
			if (hold_off > 0) begin
				rsp.ready <= 1'b0;
			end else if (stall > 0) begin
				rsp.ready <= 1'b0;
				stall <= stall - 1;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					stall <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) :
						$urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_off <= 3000;
			hold_done <= 1'b1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end
	end

	task automatic wait_idle();
		while (pending_q.size() > 0 || grant_q.size() > 0 || req.valid)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_lease(logic [LEASE_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.lease_length <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		lease_cur = v;
	endtask

	function automatic void queue_request(logic o, int unsigned dt, logic [BLK_W-1:0] b);
		request_t r;
		last_time = last_time + dt;
		if (last_time > 24'hFFFFFF) last_time = 24'hFFFFFF;
		r.op = o;
		r.req_time = last_time[TIME_W-1:0];
		r.block_id = b;
		pending_q.push_back(r);
	endfunction

	function automatic logic [BLK_W-1:0] pick_block();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k < 6) return BLK_W'($urandom_range(1, 24));
		if (k == 6) return '0;
		if (k == 7) return BLK_W'(NUM_BLOCKS);
		if (k == 8) return BLK_W'(NUM_BLOCKS + 1);
		return BLK_W'($urandom);
	endfunction

	initial begin
		cfg.valid = 1'b0;
		cfg.lease_length = LEASE_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset lease, allocation order, hits, misses, edge ids.
		queue_request(OP_ALLOC, 0, 16'hFFFF);
		queue_request(OP_ALLOC, 0, '0);
		queue_request(OP_ALLOC, 1, '0);
		queue_request(OP_ACCESS, 0, 16'd1);
		queue_request(OP_ACCESS, 0, 16'd2);
		queue_request(OP_ACCESS, 0, '0);
		queue_request(OP_ACCESS, 0, BLK_W'(NUM_BLOCKS));
		queue_request(OP_ACCESS, 0, BLK_W'(NUM_BLOCKS + 1));
		queue_request(OP_ACCESS, 0, 16'hFFFF);
		queue_request(OP_ACCESS, 0, 16'h5555);
		queue_request(OP_ACCESS, 0, 16'hAAAA);
		queue_request(OP_ACCESS, 599, 16'd1);
		queue_request(OP_ACCESS, 600, 16'd3);
		queue_request(OP_ALLOC, 0, '0);
		queue_request(OP_ALLOC, 700, '0);
		wait_idle();

		// Zero lease behaves as one, so the block expires on the next tick.
		write_lease(16'd0);
		queue_request(OP_ALLOC, 5000, '0);
		queue_request(OP_ACCESS, 0, 16'd1);
		queue_request(OP_ACCESS, 1, 16'd1);
		queue_request(OP_ALLOC, 1, '0);
		wait_idle();

		// Random phases over a spread of lease lengths, including both ends.
		for (int phase = 0; phase < 6; phase++) begin
			logic [LEASE_W-1:0] lv;
			case (phase)
				0: lv = 16'd1;
				1: lv = 16'hFFFF;
				2: lv = 16'd30;
				default: lv = LEASE_W'($urandom_range(2, 200));
			endcase
			write_lease(lv);
			if (phase == 2) hold_go = 1'b1;
			for (int i = 0; i < 88; i++) begin
				int unsigned dt;
				dt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
				if ($urandom_range(0, 30) == 0) dt = $urandom_range(0, 24'hFFFFF);
				queue_request(1'($urandom_range(0, 1)), dt, pick_block());
			end
			wait_idle();
		end
		// Push the clock to the top of the time range.
		queue_request(OP_ALLOC, 24'hFFFFFF, '0);
		queue_request(OP_ACCESS, 0, 16'd1);
		wait_idle();

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- lease_block_allocator_unit.f -----
sv/lba_pkg.sv
sv/lba_if.sv
sv/lba_ram.sv
sv/lease_block_allocator_unit.sv
bench/lba_if.sv
bench/tb_lease_block_allocator_unit.sv
